@@ hdl/b64u_pkg.sv @@
// Package for the URL-safe Base64 encoder: group record, configuration record,
// register map codes and the six-bit to ASCII character mapping.
// No dependencies.
package b64u_pkg;

	// Register map: index of each configuration register (byte address is 4 * index).
	localparam logic [1:0] REG_CHAR_62 = 2'd0;
	localparam logic [1:0] REG_CHAR_63 = 2'd1;
	localparam logic [1:0] REG_PAD     = 2'd2;

	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	// Reset values of the configuration registers.
	localparam logic [7:0] RST_CHAR_62 = 8'd45;
	localparam logic [7:0] RST_CHAR_63 = 8'd95;
	localparam logic [7:0] RST_PAD     = 8'd61;

	// Depth of the group queue between front and back.
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Character positions of a group.
	localparam logic [1:0] POS_LAST = 2'd3;

	// Base characters of the alphabet ranges.
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;

	// One group of up to three bytes, with the number present and the end mark.
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] num;
		logic       last;
	} grp_t;

	// Programmable characters.
	typedef struct packed {
		logic [7:0] char_62;
		logic [7:0] char_63;
		logic [7:0] pad;
	} cfg_t;

	// Maps a six-bit value through the URL-safe alphabet.
	function automatic logic [7:0] map_six(input logic [5:0] v, input cfg_t cfg);
		logic [7:0] ext;
		ext = {2'b00, v};
		if (v < 6'd26) begin
			return ASCII_UPPER_A + ext;
		end else if (v < 6'd52) begin
			return ASCII_LOWER_A + ext - 8'd26;
		end else if (v < 6'd62) begin
			return ASCII_ZERO + ext - 8'd52;
		end else if (v == 6'd62) begin
			return cfg.char_62;
		end else begin
			return cfg.char_63;
		end
	endfunction

endpackage

@@ hdl/b64u_front.sv @@
// Front end of the encoder: accepts message bytes and gathers them into groups.
// Depends on b64u_pkg; pushes completed or final groups into the group queue.
module b64u_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               final_byte,
	input  logic               q_full,
	output logic               q_push,
	output b64u_pkg::grp_t     q_data
);
	import b64u_pkg::*;

	logic [1:0] cnt_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	logic       accept;

	// A byte is taken whenever the queue has room for a possible group.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Build the outgoing group from the held bytes and the new one.
	always_comb begin
		q_data = '0;
		q_push = 1'b0;
		unique case (cnt_q)
			2'd1: begin
				q_data.b0   = b0_q;
				q_data.b1   = data_byte;
				q_data.num  = 2'd2;
				q_data.last = 1'b1;
				q_push      = accept && final_byte;
			end
			2'd2: begin
				q_data.b0   = b0_q;
				q_data.b1   = b1_q;
				q_data.b2   = data_byte;
				q_data.num  = 2'd3;
				q_data.last = final_byte;
				q_push      = accept;
			end
			default: begin
				q_data.b0   = data_byte;
				q_data.num  = 2'd1;
				q_data.last = 1'b1;
				q_push      = accept && final_byte;
			end
		endcase
	end

	// Group count: restarts after a push, else counts held bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			if (q_push) begin
				cnt_q <= 2'd0;
			end else if (cnt_q == 2'd1) begin
				cnt_q <= 2'd2;
			end else begin
				cnt_q <= 2'd1;
			end
		end
	end

	// Held bytes of the current group.
	always_ff @(posedge clk) begin
		if (accept && !q_push) begin
			if (cnt_q == 2'd1) begin
				b1_q <= data_byte;
			end else begin
				b0_q <= data_byte;
			end
		end
	end

	// The count never reaches three: the third byte always closes the group.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("front group count reached three");

	// A final byte always pushes a group and restarts the count.
	a_final_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_byte) |-> q_push ##1 (cnt_q == 2'd0))
		else $error("final byte did not close the group");

endmodule

@@ hdl/b64u_fifo.sv @@
// Short queue of byte groups between the front and the back of the encoder.
// Depends on b64u_pkg for the group record and the queue depth.
module b64u_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64u_pkg::grp_t wdata,
	output logic           full,
	input  logic           pop,
	output b64u_pkg::grp_t rdata,
	output logic           empty
);
	import b64u_pkg::*;

	grp_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Neither overflow nor underflow.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("group queue overflow or underflow");

endmodule

@@ hdl/b64u_back.sv @@
// Back end of the encoder (uses b64u_pkg): takes one group at a time from the queue
// and sends its four characters, one per cycle while out_ready holds, through an output register.
module b64u_back (
	input  logic           clk,
	input  logic           arst_n,
	input  b64u_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  b64u_pkg::grp_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_char,
	output logic           end_of_text
);
	import b64u_pkg::*;

	grp_t       grp_q;
	logic       busy_q;
	logic [1:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_eot_q;
	logic       adv;
	logic       grp_done;
	logic [5:0] six;
	logic       is_pad;
	logic [7:0] next_char;

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign end_of_text = out_eot_q;

	// A character moves to the output register whenever that register is free.
	assign adv      = busy_q && (!out_valid_q || out_ready);
	assign grp_done = adv && (pos_q == POS_LAST);
	assign q_pop    = !q_empty && (!busy_q || grp_done);

	// Select the six-bit field for the current position and map it.
	always_comb begin
		unique case (pos_q)
			2'd0:    six = grp_q.b0[7:2];
			2'd1:    six = {grp_q.b0[1:0], grp_q.b1[7:4]};
			2'd2:    six = {grp_q.b1[3:0], grp_q.b2[7:6]};
			default: six = grp_q.b2[5:0];
		endcase
		is_pad    = ((pos_q == 2'd2) && (grp_q.num < 2'd2)) ||
		            ((pos_q == POS_LAST) && (grp_q.num < 2'd3));
		next_char = is_pad ? cfg.pad : map_six(six, cfg);
	end

	// Current group and character position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= 2'd0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			pos_q  <= 2'd0;
		end else if (grp_done) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			grp_q <= q_data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char_q <= next_char;
			out_eot_q  <= grp_q.last && (pos_q == POS_LAST);
		end
	end

	// A busy back end with a free output register always produces a word.
	a_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !out_valid_q) |=> out_valid_q)
		else $error("back end stalled with a free output register");

	// The end mark is only produced on the last position of a group.
	a_eot_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && grp_q.last && (pos_q != POS_LAST)) |=> !out_eot_q)
		else $error("end mark on a position other than the last");

endmodule

@@ hdl/base64_url_encoder.sv @@
// Top level of the URL-safe Base64 encoder: configuration registers and the
// front end, group queue and back end. Depends on b64u_pkg and the b64u_* modules.
//
// Usage: message bytes enter one word per handshake on in_valid/in_ready, with
// final_byte set on the last byte. Characters leave one word per handshake on
// out_valid/out_ready; end_of_text marks the last character of a message.
// Each completed group of three bytes, and each final byte, yields four
// characters; short final groups are padded with the pad character.
// A group's first character passes through the group queue, the back end's group
// register and the output register after the byte that closes the group is
// accepted. Throughput: while out_ready holds, the back end sends one character
// per cycle; the input side takes a byte per cycle while the two-entry group
// queue has room. When the receiver stalls, the output register holds its word,
// the queue fills and in_ready falls until a group has been taken.
// Reset clears the held-byte count, the queue and the output valid flag, and loads
// the characters '-', '_' and '=' into the configuration registers at
// addresses 0x0, 0x4 and 0x8. Write them only while the block is idle.
module base64_url_encoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [b64u_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [b64u_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [b64u_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                final_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          out_char,
	output logic                                end_of_text
);
	import b64u_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;
	grp_t       push_data;
	grp_t       pop_data;
	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;

	// Register access.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.char_62 <= RST_CHAR_62;
			cfg_q.char_63 <= RST_CHAR_63;
			cfg_q.pad     <= RST_PAD;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CHAR_62: cfg_q.char_62 <= pwdata[7:0];
				REG_CHAR_63: cfg_q.char_63 <= pwdata[7:0];
				REG_PAD:     cfg_q.pad     <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		unique case (reg_idx)
			REG_CHAR_62: prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.char_62};
			REG_CHAR_63: prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.char_63};
			REG_PAD:     prdata = {{(APB_DATA_W-8){1'b0}}, cfg_q.pad};
			default:     prdata = '0;
		endcase
	end

	b64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (push_data)
	);

	b64u_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_data),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (pop_data),
		.empty  (q_empty)
	);

	b64u_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.end_of_text (end_of_text)
	);

endmodule
